[hw/rtl/bfhs_pkg.sv]
// Shared definitions for the back/forward history stacks.
// Holds the stack depth, derived widths, command and status codes and the
// control struct between the controller and the datapath. No dependencies.
package bfhs_pkg;

	localparam int HISTORY_DEPTH = 16;
	localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CW = $clog2(HISTORY_DEPTH + 1);
	localparam int ENTRY_W = 64;

	localparam logic [1:0] CMD_OPEN = 2'd0;
	localparam logic [1:0] CMD_BACK = 2'd1;
	localparam logic [1:0] CMD_FORWARD = 2'd2;
	localparam logic [1:0] CMD_CLOSE = 2'd3;

	localparam logic [2:0] ST_OPENED = 3'd0;
	localparam logic [2:0] ST_BACK = 3'd1;
	localparam logic [2:0] ST_FORWARD = 3'd2;
	localparam logic [2:0] ST_CLOSED_PREV = 3'd3;
	localparam logic [2:0] ST_CLOSED_EMPTY = 3'd4;
	localparam logic [2:0] ST_NO_BACK = 3'd5;
	localparam logic [2:0] ST_NO_FORWARD = 3'd6;
	localparam logic [2:0] ST_NOTHING_OPEN = 3'd7;

	typedef struct packed {
		logic load;
		logic exec;
	} ctl_t;

endpackage

[hw/rtl/back_forward_history_stacks.sv]
// Top level of the back/forward history stacks.
// Joins the controller bfhs_ctrl and the datapath bfhs_dp; depends on bfhs_pkg.
//
// For each item, busy rises at the edge that accepts it,
// the stack RAMs deliver their registered read in the following cycle, and
// the new state and result are written at the end of that cycle. The result
// is then shown for exactly one cycle with done high, and a new item may be
// accepted at the edge that ends that cycle. Results cannot be held off by
// the receiver, so it must take each one while done is high.
module back_forward_history_stacks (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [15:0] site_id,
	input  logic [15:0] user_id,
	input  logic [31:0] visit_time,
	output logic        done,
	output logic [2:0]  status,
	output logic        has_current,
	output logic [15:0] current_site,
	output logic [15:0] current_user,
	output logic [31:0] current_time,
	output logic [4:0]  back_count,
	output logic [4:0]  forward_count,
	output logic        dropped_oldest
);

	bfhs_pkg::ctl_t ctl;

	bfhs_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.done(done),
		.ctl(ctl)
	);

	bfhs_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.command(command),
		.site_id(site_id),
		.user_id(user_id),
		.visit_time(visit_time),
		.status(status),
		.has_current(has_current),
		.current_site(current_site),
		.current_user(current_user),
		.current_time(current_time),
		.back_count(back_count),
		.forward_count(forward_count),
		.dropped_oldest(dropped_oldest)
	);

endmodule

[hw/rtl/bfhs_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Used for both history stacks. No dependencies.
module bfhs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                         wr_data,
	input  logic                                     rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[hw/rtl/bfhs_ctrl.sv]
// Controller for the history stacks: accepts an item, runs the update step
// and raises the result strobe. Depends on bfhs_pkg.
module bfhs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	output logic             done,
	output bfhs_pkg::ctl_t   ctl
);

	typedef enum logic {S_IDLE, S_EXEC} state_t;

	state_t state_q;
	logic busy_q;
	logic done_q;

	assign ctl.load = start && !busy_q;
	assign ctl.exec = (state_q == S_EXEC);
	assign busy = busy_q;
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
						busy_q <= 1'b1;
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

[hw/rtl/bfhs_dp.sv]
// Datapath for the history stacks: current entry, stack counters, the two
// stack RAMs and the result registers. Depends on bfhs_pkg and bfhs_ram.
module bfhs_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bfhs_pkg::ctl_t                   ctl,
	input  logic [1:0]                       command,
	input  logic [15:0]                      site_id,
	input  logic [15:0]                      user_id,
	input  logic [31:0]                      visit_time,
	output logic [2:0]                       status,
	output logic                             has_current,
	output logic [15:0]                      current_site,
	output logic [15:0]                      current_user,
	output logic [31:0]                      current_time,
	output logic [4:0]                       back_count,
	output logic [4:0]                       forward_count,
	output logic                             dropped_oldest
);

	localparam int AW = bfhs_pkg::AW;
	localparam int CW = bfhs_pkg::CW;
	localparam int EW = bfhs_pkg::ENTRY_W;
	localparam logic [AW-1:0] TOP_LAST = AW'(bfhs_pkg::HISTORY_DEPTH - 1);
	localparam logic [CW-1:0] FILL_FULL = CW'(bfhs_pkg::HISTORY_DEPTH);

	logic [1:0] cmd_q;
	logic [EW-1:0] new_entry_q;
	logic [EW-1:0] cur_entry_q;
	logic cur_valid_q;
	logic [AW-1:0] back_top_q;
	logic [CW-1:0] back_fill_q;
	logic [CW-1:0] fwd_fill_q;
	logic [2:0] status_q;
	logic dropped_q;

	logic [AW-1:0] back_prev;
	logic [AW-1:0] back_next;
	logic [AW-1:0] fwd_rd_addr;
	logic [EW-1:0] back_rd_data;
	logic [EW-1:0] fwd_rd_data;

	logic back_wr;
	logic fwd_wr;
	logic [EW-1:0] cur_entry_d;
	logic cur_valid_d;
	logic [AW-1:0] back_top_d;
	logic [CW-1:0] back_fill_d;
	logic [CW-1:0] fwd_fill_d;
	logic [2:0] status_d;
	logic dropped_d;

	assign back_prev = (back_top_q == '0) ? TOP_LAST : back_top_q - AW'(1);
	assign back_next = (back_top_q == TOP_LAST) ? '0 : back_top_q + AW'(1);
	assign fwd_rd_addr = AW'(fwd_fill_q - CW'(1));

	bfhs_ram #(
		.WIDTH(EW),
		.DEPTH(bfhs_pkg::HISTORY_DEPTH)
	) u_back_ram (
		.clk(clk),
		.wr_en(back_wr),
		.wr_addr(back_top_q),
		.wr_data(cur_entry_q),
		.rd_en(ctl.load),
		.rd_addr(back_prev),
		.rd_data(back_rd_data)
	);

	bfhs_ram #(
		.WIDTH(EW),
		.DEPTH(bfhs_pkg::HISTORY_DEPTH)
	) u_fwd_ram (
		.clk(clk),
		.wr_en(fwd_wr),
		.wr_addr(AW'(fwd_fill_q)),
		.wr_data(cur_entry_q),
		.rd_en(ctl.load),
		.rd_addr(fwd_rd_addr),
		.rd_data(fwd_rd_data)
	);

	always_comb begin
		back_wr = 1'b0;
		fwd_wr = 1'b0;
		cur_entry_d = cur_entry_q;
		cur_valid_d = cur_valid_q;
		back_top_d = back_top_q;
		back_fill_d = back_fill_q;
		fwd_fill_d = fwd_fill_q;
		status_d = bfhs_pkg::ST_OPENED;
		dropped_d = 1'b0;
		case (cmd_q)
			bfhs_pkg::CMD_OPEN: begin
				back_wr = cur_valid_q;
				fwd_fill_d = '0;
				cur_entry_d = new_entry_q;
				cur_valid_d = 1'b1;
				status_d = bfhs_pkg::ST_OPENED;
			end
			bfhs_pkg::CMD_BACK: begin
				if (back_fill_q == '0) begin
					status_d = bfhs_pkg::ST_NO_BACK;
				end else begin
					if (cur_valid_q && (fwd_fill_q < FILL_FULL)) begin
						fwd_wr = 1'b1;
						fwd_fill_d = fwd_fill_q + CW'(1);
					end
					cur_entry_d = back_rd_data;
					cur_valid_d = 1'b1;
					back_top_d = back_prev;
					back_fill_d = back_fill_q - CW'(1);
					status_d = bfhs_pkg::ST_BACK;
				end
			end
			bfhs_pkg::CMD_FORWARD: begin
				if (fwd_fill_q == '0) begin
					status_d = bfhs_pkg::ST_NO_FORWARD;
				end else begin
					back_wr = cur_valid_q;
					fwd_fill_d = fwd_fill_q - CW'(1);
					cur_entry_d = fwd_rd_data;
					cur_valid_d = 1'b1;
					status_d = bfhs_pkg::ST_FORWARD;
				end
			end
			default: begin
				if (!cur_valid_q) begin
					status_d = bfhs_pkg::ST_NOTHING_OPEN;
				end else if (back_fill_q != '0) begin
					cur_entry_d = back_rd_data;
					back_top_d = back_prev;
					back_fill_d = back_fill_q - CW'(1);
					status_d = bfhs_pkg::ST_CLOSED_PREV;
				end else begin
					cur_entry_d = '0;
					cur_valid_d = 1'b0;
					fwd_fill_d = '0;
					status_d = bfhs_pkg::ST_CLOSED_EMPTY;
				end
			end
		endcase
		if (back_wr) begin
			back_top_d = back_next;
			if (back_fill_q < FILL_FULL) begin
				back_fill_d = back_fill_q + CW'(1);
			end else begin
				dropped_d = 1'b1;
			end
		end
		if (!ctl.exec) begin
			back_wr = 1'b0;
			fwd_wr = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= command;
			new_entry_q <= {site_id, user_id, visit_time};
		end
		if (ctl.exec) begin
			status_q <= status_d;
			dropped_q <= dropped_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_entry_q <= '0;
			cur_valid_q <= 1'b0;
			back_top_q <= '0;
			back_fill_q <= '0;
			fwd_fill_q <= '0;
		end else if (ctl.exec) begin
			cur_entry_q <= cur_entry_d;
			cur_valid_q <= cur_valid_d;
			back_top_q <= back_top_d;
			back_fill_q <= back_fill_d;
			fwd_fill_q <= fwd_fill_d;
		end
	end

	assign status = status_q;
	assign dropped_oldest = dropped_q;
	assign has_current = cur_valid_q;
	assign current_site = cur_entry_q[63:48];
	assign current_user = cur_entry_q[47:32];
	assign current_time = cur_entry_q[31:0];
	assign back_count = 5'(back_fill_q);
	assign forward_count = 5'(fwd_fill_q);

endmodule

[tb/testbench.sv]
// Self-checking testbench for back_forward_history_stacks, driving commands through start/busy.
// It predicts every result from its own model of the two history stacks and checks each done strobe.
// Depends on bfhs_pkg and the back_forward_history_stacks RTL.
module testbench;

	localparam int AW = bfhs_pkg::AW;

	typedef struct packed {
		logic [15:0] site;
		logic [15:0] user;
		logic [31:0] stamp;
	} visit_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        has_current;
		logic [15:0] site;
		logic [15:0] user;
		logic [31:0] stamp;
		logic [4:0]  back_count;
		logic [4:0]  forward_count;
		logic        dropped;
	} view_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  command;
	logic [15:0] site_id;
	logic [15:0] user_id;
	logic [31:0] visit_time;
	logic        done;
	logic [2:0]  status;
	logic        has_current;
	logic [15:0] current_site;
	logic [15:0] current_user;
	logic [31:0] current_time;
	logic [4:0]  back_count;
	logic [4:0]  forward_count;
	logic        dropped_oldest;

	visit_t back_ring [bfhs_pkg::HISTORY_DEPTH];
	visit_t forward_pile [bfhs_pkg::HISTORY_DEPTH];
	int     ring_top;
	int     ring_fill;
	int     pile_fill;
	visit_t open_visit;
	logic   open_valid;

	view_t  expected_views [$];
	int     mismatches;
	int     items_sent;
	int     results_seen;
	int     overwrites;
	int     deepest_forward;
	bit     gapless;

	back_forward_history_stacks uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.site_id(site_id),
		.user_id(user_id),
		.visit_time(visit_time),
		.done(done),
		.status(status),
		.has_current(has_current),
		.current_site(current_site),
		.current_user(current_user),
		.current_time(current_time),
		.back_count(back_count),
		.forward_count(forward_count),
		.dropped_oldest(dropped_oldest)
	);

	always #4 clk = ~clk;

	function automatic logic ring_push(visit_t e);
		back_ring[AW'(ring_top)] = e;
		ring_top = (ring_top + 1) % bfhs_pkg::HISTORY_DEPTH;
		if (ring_fill < bfhs_pkg::HISTORY_DEPTH) begin
			ring_fill++;
			return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic visit_t ring_pop();
		ring_top = (ring_top == 0) ? bfhs_pkg::HISTORY_DEPTH - 1 : ring_top - 1;
		ring_fill--;
		return back_ring[AW'(ring_top)];
	endfunction

	task automatic apply_command(input logic [1:0] cmd, input visit_t v, output view_t r);
		logic   drop;
		logic [2:0] st;
		visit_t shown;
		begin
			drop = 1'b0;
			st = bfhs_pkg::ST_OPENED;
			case (cmd)
				bfhs_pkg::CMD_OPEN: begin
					if (open_valid)
						drop = ring_push(open_visit);
					pile_fill = 0;
					open_visit = v;
					open_valid = 1'b1;
					st = bfhs_pkg::ST_OPENED;
				end
				bfhs_pkg::CMD_BACK: begin
					if (ring_fill == 0) begin
						st = bfhs_pkg::ST_NO_BACK;
					end else begin
						if (open_valid && pile_fill < bfhs_pkg::HISTORY_DEPTH) begin
							forward_pile[AW'(pile_fill)] = open_visit;
							pile_fill++;
						end
						open_visit = ring_pop();
						open_valid = 1'b1;
						st = bfhs_pkg::ST_BACK;
					end
				end
				bfhs_pkg::CMD_FORWARD: begin
					if (pile_fill == 0) begin
						st = bfhs_pkg::ST_NO_FORWARD;
					end else begin
						pile_fill--;
						shown = forward_pile[AW'(pile_fill)];
						if (open_valid)
							drop = ring_push(open_visit);
						open_visit = shown;
						open_valid = 1'b1;
						st = bfhs_pkg::ST_FORWARD;
					end
				end
				default: begin
					if (!open_valid) begin
						st = bfhs_pkg::ST_NOTHING_OPEN;
					end else if (ring_fill != 0) begin
						open_visit = ring_pop();
						st = bfhs_pkg::ST_CLOSED_PREV;
					end else begin
						open_visit = '0;
						open_valid = 1'b0;
						pile_fill = 0;
						st = bfhs_pkg::ST_CLOSED_EMPTY;
					end
				end
			endcase
			shown = open_valid ? open_visit : visit_t'(0);
			r.status = st;
			r.has_current = open_valid;
			r.site = shown.site;
			r.user = shown.user;
			r.stamp = shown.stamp;
			r.back_count = ring_fill[4:0];
			r.forward_count = pile_fill[4:0];
			r.dropped = drop;
			if (drop)
				overwrites++;
			if (pile_fill > deepest_forward)
				deepest_forward = pile_fill;
		end
	endtask

	function automatic int pick_gap();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(6, 40);
		return $urandom_range(0, 2);
	endfunction

	function automatic logic [31:0] pick_value(int bits);
		logic [31:0] mask;
		mask = (bits == 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 1);
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return mask;
			default: return $urandom() & mask;
		endcase
	endfunction

	function automatic visit_t pick_visit();
		visit_t v;
		v.site = 16'(pick_value(16));
		v.user = 16'(pick_value(16));
		v.stamp = pick_value(32);
		return v;
	endfunction

	task automatic send_item(input logic [1:0] cmd, input visit_t v);
		int    gap;
		view_t want;
		begin
			gap = gapless ? 0 : pick_gap();
			if (gap > 0) begin
				@(negedge clk);
				start = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			command = cmd;
			site_id = v.site;
			user_id = v.user;
			visit_time = v.stamp;
			start = 1'b1;
			@(posedge clk);
			while (busy)
				@(posedge clk);
			apply_command(cmd, v, want);
			expected_views.push_back(want);
			items_sent++;
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		view_t want;
		if (arst_n && done) begin
			results_seen++;
			if (expected_views.size() == 0) begin
				$display("%0t: result with no item outstanding, status %0h", $time, status);
				mismatches++;
			end else begin
				want = expected_views.pop_front();
				check_field("status", 32'(want.status), 32'(status));
				check_field("has_current", 32'(want.has_current), 32'(has_current));
				check_field("current_site", 32'(want.site), 32'(current_site));
				check_field("current_user", 32'(want.user), 32'(current_user));
				check_field("current_time", want.stamp, current_time);
				check_field("back_count", 32'(want.back_count), 32'(back_count));
				check_field("forward_count", 32'(want.forward_count), 32'(forward_count));
				check_field("dropped_oldest", 32'(want.dropped), 32'(dropped_oldest));
			end
		end
	end

	task automatic test_empty_history();
		send_item(bfhs_pkg::CMD_BACK, pick_visit());
		send_item(bfhs_pkg::CMD_FORWARD, pick_visit());
		send_item(bfhs_pkg::CMD_CLOSE, pick_visit());
	endtask

	task automatic test_field_extremes();
		send_item(bfhs_pkg::CMD_OPEN, '0);
		send_item(bfhs_pkg::CMD_OPEN, '1);
		send_item(bfhs_pkg::CMD_OPEN, {16'hA5A5, 16'h5A5A, 32'hAAAA_AAAA});
		send_item(bfhs_pkg::CMD_OPEN, {16'h5A5A, 16'hA5A5, 32'h5555_5555});
		send_item(bfhs_pkg::CMD_BACK, pick_visit());
		send_item(bfhs_pkg::CMD_BACK, pick_visit());
		send_item(bfhs_pkg::CMD_FORWARD, pick_visit());
		send_item(bfhs_pkg::CMD_FORWARD, pick_visit());
		send_item(bfhs_pkg::CMD_FORWARD, pick_visit());
	endtask

	task automatic test_close_paths();
		send_item(bfhs_pkg::CMD_BACK, pick_visit());
		repeat (4)
			send_item(bfhs_pkg::CMD_CLOSE, pick_visit());
		send_item(bfhs_pkg::CMD_CLOSE, pick_visit());
		send_item(bfhs_pkg::CMD_BACK, pick_visit());
		send_item(bfhs_pkg::CMD_FORWARD, pick_visit());
		send_item(bfhs_pkg::CMD_OPEN, pick_visit());
		send_item(bfhs_pkg::CMD_BACK, pick_visit());
	endtask

	// Most bursts lean on one command so that the stacks fill, overflow and drain.
	task automatic test_random_sessions(input int total);
		int         mode;
		int         burst;
		logic [1:0] lean;
		logic [1:0] cmd;
		begin
			while (items_sent < total) begin
				mode = $urandom_range(0, 9);
				burst = $urandom_range(1, 24);
				gapless = ($urandom_range(0, 3) == 0);
				if (mode < 4)
					lean = bfhs_pkg::CMD_OPEN;
				else if (mode < 6)
					lean = bfhs_pkg::CMD_BACK;
				else if (mode < 8)
					lean = bfhs_pkg::CMD_FORWARD;
				else
					lean = bfhs_pkg::CMD_CLOSE;
				repeat (burst) begin
					if (mode != 8 && $urandom_range(0, 99) < 80)
						cmd = lean;
					else
						cmd = 2'($urandom_range(0, 3));
					send_item(cmd, pick_visit());
				end
			end
			gapless = 1'b0;
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		command = bfhs_pkg::CMD_OPEN;
		site_id = '0;
		user_id = '0;
		visit_time = '0;
		ring_top = 0;
		ring_fill = 0;
		pile_fill = 0;
		open_visit = '0;
		open_valid = 1'b0;
		mismatches = 0;
		items_sent = 0;
		results_seen = 0;
		overwrites = 0;
		deepest_forward = 0;
		gapless = 1'b0;
		for (int i = 0; i < bfhs_pkg::HISTORY_DEPTH; i++) begin
			back_ring[AW'(i)] = '0;
			forward_pile[AW'(i)] = '0;
		end
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		test_empty_history();
		test_field_extremes();
		test_close_paths();
		test_random_sessions(1500);

		@(negedge clk);
		start = 1'b0;
		while (expected_views.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Ran %0d commands and checked %0d results.", items_sent, results_seen);
		$display("The back stack overwrote its oldest entry %0d times; forward depth reached %0d.",
			overwrites, deepest_forward);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#5000000;
		$display("Timed out with %0d results outstanding.", expected_views.size());
		$display("TEST FAILED");
		$finish;
	end

endmodule
